// File: hw/rtl/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared types, constants and the shift/saturate helper for the point rotator.
// ----------------------------------------------------------------------------
package qpr_pkg;

    localparam int COORD_W        = 31;
    localparam int QUAT_W         = 32;
    localparam int PROD_W         = COORD_W + QUAT_W;
    localparam int ACC_W          = 64;
    localparam int QUAT_FRAC_BITS = 30;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    localparam quat_t ROT_W_RESET = quat_t'(32'sd1073741824);

    // bounds of the intermediate t = q * p and of the rotated result
    localparam acc_t MID_MAX = acc_t'(64'sd1073741823);
    localparam acc_t MID_MIN = acc_t'(-64'sd1073741824);
    localparam acc_t OUT_MAX = acc_t'(64'sd536870912);
    localparam acc_t OUT_MIN = acc_t'(-64'sd536870912);

    typedef enum logic [1:0] {
        REG_ROT_X = 2'd0,
        REG_ROT_Y = 2'd1,
        REG_ROT_Z = 2'd2,
        REG_ROT_W = 2'd3
    } reg_idx_t;

    typedef struct packed {
        quat_t x;
        quat_t y;
        quat_t z;
        quat_t w;
    } quat_s_t;

    typedef struct packed {
        logic valid;
        logic batch_end;
        logic clip;
    } ctrl_t;

    // products of q * p
    typedef struct packed {
        prod_t y_pz;
        prod_t z_py;
        prod_t w_px;
        prod_t z_px;
        prod_t x_pz;
        prod_t w_py;
        prod_t x_py;
        prod_t y_px;
        prod_t w_pz;
        prod_t x_px;
        prod_t y_py;
        prod_t z_pz;
    } fwd_prod_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t w;
    } mid_t;

    // products of t * conj(q)
    typedef struct packed {
        prod_t tx_w;
        prod_t ty_z;
        prod_t tz_y;
        prod_t tw_x;
        prod_t tx_z;
        prod_t ty_w;
        prod_t tz_x;
        prod_t tw_y;
        prod_t ty_x;
        prod_t tx_y;
        prod_t tz_w;
        prod_t tw_z;
    } conj_prod_t;

    typedef struct packed {
        coord_t val;
        logic   clip;
    } sat_t;

    function automatic acc_t ext(input prod_t p);
        return acc_t'(p);
    endfunction

    // arithmetic shift out the quaternion scale, then clamp
    function automatic sat_t shift_sat(input acc_t acc, input acc_t lo, input acc_t hi);
        acc_t s;
        sat_t r;
        s = acc >>> QUAT_FRAC_BITS;
        priority if (s > hi) begin
            r.clip = 1'b1;
            r.val  = hi[COORD_W-1:0];
        end else if (s < lo) begin
            r.clip = 1'b1;
            r.val  = lo[COORD_W-1:0];
        end else begin
            r.clip = 1'b0;
            r.val  = s[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/quaternion_point_rotator_top.sv
// ----------------------------------------------------------------------------
// quaternion_point_rotator_top: rotates points by q * p * conj(q)
// Two multiply and two sum stages, each registered, lie between request and m_valid.
// Throughput one point per cycle while m_ready is high; each stage holds only while the one after it is full.
// Synchronous active-low reset empties the pipeline and sets q to identity.
// ----------------------------------------------------------------------------
module quaternion_point_rotator_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [30:0]    s_point_x,
    input  logic signed [30:0]    s_point_y,
    input  logic signed [30:0]    s_point_z,
    input  logic                  s_batch_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [30:0]    m_rotated_x,
    output logic signed [30:0]    m_rotated_y,
    output logic signed [30:0]    m_rotated_z,
    output logic                  m_clipped,
    output logic                  m_batch_end_out
);
    import qpr_pkg::*;

    quat_s_t    rot_reg;
    ctrl_t      ctrl_in;
    ctrl_t      ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
    fwd_prod_t  fwd_prod;
    mid_t       mid;
    conj_prod_t conj_prod;
    logic       en1, en2, en3, en4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg.x <= '0;
            rot_reg.y <= '0;
            rot_reg.z <= '0;
            rot_reg.w <= ROT_W_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ROT_X: rot_reg.x <= cfg_wdata;
                REG_ROT_Y: rot_reg.y <= cfg_wdata;
                REG_ROT_Z: rot_reg.z <= cfg_wdata;
                REG_ROT_W: rot_reg.w <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the next one moves
    assign en4     = !ctrl_s4.valid || m_ready;
    assign en3     = !ctrl_s3.valid || en4;
    assign en2     = !ctrl_s2.valid || en3;
    assign en1     = !ctrl_s1.valid || en2;
    assign s_ready = en1;

    assign ctrl_in = '{valid: s_valid, batch_end: s_batch_end, clip: 1'b0};

    qpr_fwd_prod u_fwd_prod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en1),
        .rot      (rot_reg),
        .px       (s_point_x),
        .py       (s_point_y),
        .pz       (s_point_z),
        .ctrl_in  (ctrl_in),
        .prod_out (fwd_prod),
        .ctrl_out (ctrl_s1)
    );

    qpr_fwd_sum u_fwd_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en2),
        .prod_in  (fwd_prod),
        .ctrl_in  (ctrl_s1),
        .mid_out  (mid),
        .ctrl_out (ctrl_s2)
    );

    qpr_conj_prod u_conj_prod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en3),
        .rot      (rot_reg),
        .mid_in   (mid),
        .ctrl_in  (ctrl_s2),
        .prod_out (conj_prod),
        .ctrl_out (ctrl_s3)
    );

    qpr_conj_sum u_conj_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en4),
        .prod_in  (conj_prod),
        .ctrl_in  (ctrl_s3),
        .rx       (m_rotated_x),
        .ry       (m_rotated_y),
        .rz       (m_rotated_z),
        .ctrl_out (ctrl_s4)
    );

    assign m_valid         = ctrl_s4.valid;
    assign m_clipped       = ctrl_s4.clip;
    assign m_batch_end_out = ctrl_s4.batch_end;

endmodule

// File: hw/rtl/qpr_fwd_prod.sv
// ----------------------------------------------------------------------------
// qpr_fwd_prod
// First multiply stage: the twelve products of q and the point.
// ----------------------------------------------------------------------------
module qpr_fwd_prod (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  qpr_pkg::quat_s_t  rot,
    input  qpr_pkg::coord_t   px,
    input  qpr_pkg::coord_t   py,
    input  qpr_pkg::coord_t   pz,
    input  qpr_pkg::ctrl_t    ctrl_in,
    output qpr_pkg::fwd_prod_t prod_out,
    output qpr_pkg::ctrl_t    ctrl_out
);
    import qpr_pkg::*;

    fwd_prod_t prod_reg;
    fwd_prod_t prod_next;
    logic      valid_reg;
    logic      batch_end_reg;

    always_comb begin
        prod_next.y_pz = prod_t'(rot.y) * prod_t'(pz);
        prod_next.z_py = prod_t'(rot.z) * prod_t'(py);
        prod_next.w_px = prod_t'(rot.w) * prod_t'(px);
        prod_next.z_px = prod_t'(rot.z) * prod_t'(px);
        prod_next.x_pz = prod_t'(rot.x) * prod_t'(pz);
        prod_next.w_py = prod_t'(rot.w) * prod_t'(py);
        prod_next.x_py = prod_t'(rot.x) * prod_t'(py);
        prod_next.y_px = prod_t'(rot.y) * prod_t'(px);
        prod_next.w_pz = prod_t'(rot.w) * prod_t'(pz);
        prod_next.x_px = prod_t'(rot.x) * prod_t'(px);
        prod_next.y_py = prod_t'(rot.y) * prod_t'(py);
        prod_next.z_pz = prod_t'(rot.z) * prod_t'(pz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
        if (en) begin
            prod_reg      <= prod_next;
            batch_end_reg <= ctrl_in.batch_end;
        end
    end

    assign prod_out = prod_reg;
    assign ctrl_out = '{valid: valid_reg, batch_end: batch_end_reg, clip: 1'b0};

endmodule

// File: hw/rtl/qpr_fwd_sum.sv
// ----------------------------------------------------------------------------
// qpr_fwd_sum
// Sums the q * p products, shifts and saturates to the intermediate t.
// ----------------------------------------------------------------------------
module qpr_fwd_sum (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  qpr_pkg::fwd_prod_t prod_in,
    input  qpr_pkg::ctrl_t     ctrl_in,
    output qpr_pkg::mid_t      mid_out,
    output qpr_pkg::ctrl_t     ctrl_out
);
    import qpr_pkg::*;

    acc_t  acc_x, acc_y, acc_z, acc_w;
    sat_t  sat_x, sat_y, sat_z, sat_w;
    mid_t  mid_reg;
    mid_t  mid_next;
    logic  valid_reg;
    logic  batch_end_reg;
    logic  clip_reg;
    logic  clip_next;

    always_comb begin
        acc_x = ext(prod_in.y_pz) - ext(prod_in.z_py) + ext(prod_in.w_px);
        acc_y = ext(prod_in.z_px) - ext(prod_in.x_pz) + ext(prod_in.w_py);
        acc_z = ext(prod_in.x_py) - ext(prod_in.y_px) + ext(prod_in.w_pz);
        acc_w = acc_t'(0) - ext(prod_in.x_px) - ext(prod_in.y_py) - ext(prod_in.z_pz);
        sat_x = shift_sat(acc_x, MID_MIN, MID_MAX);
        sat_y = shift_sat(acc_y, MID_MIN, MID_MAX);
        sat_z = shift_sat(acc_z, MID_MIN, MID_MAX);
        sat_w = shift_sat(acc_w, MID_MIN, MID_MAX);
        mid_next.x = sat_x.val;
        mid_next.y = sat_y.val;
        mid_next.z = sat_z.val;
        mid_next.w = sat_w.val;
        clip_next  = ctrl_in.clip | sat_x.clip | sat_y.clip | sat_z.clip | sat_w.clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
        if (en) begin
            mid_reg       <= mid_next;
            batch_end_reg <= ctrl_in.batch_end;
            clip_reg      <= clip_next;
        end
    end

    assign mid_out  = mid_reg;
    assign ctrl_out = '{valid: valid_reg, batch_end: batch_end_reg, clip: clip_reg};

endmodule

// File: hw/rtl/qpr_conj_prod.sv
// ----------------------------------------------------------------------------
// qpr_conj_prod
// Second multiply stage: the products of t with the parts of q.
// ----------------------------------------------------------------------------
module qpr_conj_prod (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  qpr_pkg::quat_s_t    rot,
    input  qpr_pkg::mid_t       mid_in,
    input  qpr_pkg::ctrl_t      ctrl_in,
    output qpr_pkg::conj_prod_t prod_out,
    output qpr_pkg::ctrl_t      ctrl_out
);
    import qpr_pkg::*;

    conj_prod_t prod_reg;
    conj_prod_t prod_next;
    logic       valid_reg;
    logic       batch_end_reg;
    logic       clip_reg;

    always_comb begin
        prod_next.tx_w = prod_t'(mid_in.x) * prod_t'(rot.w);
        prod_next.ty_z = prod_t'(mid_in.y) * prod_t'(rot.z);
        prod_next.tz_y = prod_t'(mid_in.z) * prod_t'(rot.y);
        prod_next.tw_x = prod_t'(mid_in.w) * prod_t'(rot.x);
        prod_next.tx_z = prod_t'(mid_in.x) * prod_t'(rot.z);
        prod_next.ty_w = prod_t'(mid_in.y) * prod_t'(rot.w);
        prod_next.tz_x = prod_t'(mid_in.z) * prod_t'(rot.x);
        prod_next.tw_y = prod_t'(mid_in.w) * prod_t'(rot.y);
        prod_next.ty_x = prod_t'(mid_in.y) * prod_t'(rot.x);
        prod_next.tx_y = prod_t'(mid_in.x) * prod_t'(rot.y);
        prod_next.tz_w = prod_t'(mid_in.z) * prod_t'(rot.w);
        prod_next.tw_z = prod_t'(mid_in.w) * prod_t'(rot.z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
        if (en) begin
            prod_reg      <= prod_next;
            batch_end_reg <= ctrl_in.batch_end;
            clip_reg      <= ctrl_in.clip;
        end
    end

    assign prod_out = prod_reg;
    assign ctrl_out = '{valid: valid_reg, batch_end: batch_end_reg, clip: clip_reg};

endmodule

// File: hw/rtl/qpr_conj_sum.sv
// ----------------------------------------------------------------------------
// qpr_conj_sum
// Sums t * conj(q) into the rotated point, saturates, holds the result.
// ----------------------------------------------------------------------------
module qpr_conj_sum (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  qpr_pkg::conj_prod_t prod_in,
    input  qpr_pkg::ctrl_t      ctrl_in,
    output qpr_pkg::coord_t     rx,
    output qpr_pkg::coord_t     ry,
    output qpr_pkg::coord_t     rz,
    output qpr_pkg::ctrl_t      ctrl_out
);
    import qpr_pkg::*;

    acc_t   acc_x, acc_y, acc_z;
    sat_t   sat_x, sat_y, sat_z;
    coord_t rx_reg, ry_reg, rz_reg;
    logic   valid_reg;
    logic   batch_end_reg;
    logic   clip_reg;
    logic   clip_next;

    // conj(q) negates x, y, z, which flips the signs of those terms
    always_comb begin
        acc_x = ext(prod_in.tx_w) - ext(prod_in.ty_z) + ext(prod_in.tz_y)
              - ext(prod_in.tw_x);
        acc_y = ext(prod_in.tx_z) + ext(prod_in.ty_w) - ext(prod_in.tz_x)
              - ext(prod_in.tw_y);
        acc_z = ext(prod_in.ty_x) - ext(prod_in.tx_y) + ext(prod_in.tz_w)
              - ext(prod_in.tw_z);
        sat_x = shift_sat(acc_x, OUT_MIN, OUT_MAX);
        sat_y = shift_sat(acc_y, OUT_MIN, OUT_MAX);
        sat_z = shift_sat(acc_z, OUT_MIN, OUT_MAX);
        clip_next = ctrl_in.clip | sat_x.clip | sat_y.clip | sat_z.clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
        if (en) begin
            rx_reg        <= sat_x.val;
            ry_reg        <= sat_y.val;
            rz_reg        <= sat_z.val;
            batch_end_reg <= ctrl_in.batch_end;
            clip_reg      <= clip_next;
        end
    end

    assign rx       = rx_reg;
    assign ry       = ry_reg;
    assign rz       = rz_reg;
    assign ctrl_out = '{valid: valid_reg, batch_end: batch_end_reg, clip: clip_reg};

endmodule

// File: hw/rtl/qpr_checker.sv
// ----------------------------------------------------------------------------
// qpr_checker
// Port-level checks on the point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module qpr_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic signed [30:0]    s_point_x,
    input  logic signed [30:0]    s_point_y,
    input  logic signed [30:0]    s_point_z,
    input  logic                  s_batch_end,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [30:0]    m_rotated_x,
    input  logic signed [30:0]    m_rotated_y,
    input  logic signed [30:0]    m_rotated_z,
    input  logic                  m_clipped,
    input  logic                  m_batch_end_out
);
    import qpr_pkg::*;

    logic unused_ok;
    assign unused_ok = cfg_wr_en ^ (^cfg_index) ^ (^cfg_wdata) ^ s_valid ^ (^s_point_x)
                     ^ (^s_point_y) ^ (^s_point_z) ^ s_batch_end;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input only stalls when a finished result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with output free");

    // results always lie inside the saturation range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (acc_t'(m_rotated_x) <= OUT_MAX && acc_t'(m_rotated_x) >= OUT_MIN
                  && acc_t'(m_rotated_y) <= OUT_MAX && acc_t'(m_rotated_y) >= OUT_MIN
                  && acc_t'(m_rotated_z) <= OUT_MAX && acc_t'(m_rotated_z) >= OUT_MIN))
        else $error("rotated coordinate out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rotated_x) && $stable(m_rotated_y)
                             && $stable(m_rotated_z) && $stable(m_clipped)
                             && $stable(m_batch_end_out))
        else $error("stalled result changed");

endmodule

bind quaternion_point_rotator_top qpr_checker u_qpr_checker (.*);
